### rtl/core/bsfd_pkg.sv
// Shared types and constants for the base-32 sensor frame deframer.
// Depends on nothing; every other file of the block imports it.
package bsfd_pkg;

    // Frame geometry.
    localparam int FRAME_DIGITS = 14;
    localparam int STORE_DEPTH  = 14;
    localparam int POS_W        = 4;
    localparam int DIGIT_W      = 5;

    // Result field widths.
    localparam int TS_W   = 35;
    localparam int FORCE_W = 15;
    localparam int STIM_W = 5;
    localparam int FREQ_W = 15;
    localparam int SEQ_W  = 16;

    // Command queue between the front and the back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;
    localparam int QUEUE_CW    = 3;

    // Marker and digit characters.
    localparam logic [7:0] CH_START = 8'h53;  // 'S'
    localparam logic [7:0] CH_END   = 8'h45;  // 'E'
    localparam logic [7:0] CH_SEQ   = 8'h59;  // 'Y'
    localparam logic [7:0] CH_SKIP  = 8'h4E;  // 'N'
    localparam logic [7:0] CH_DEC0  = 8'h30;  // '0'
    localparam logic [7:0] CH_DEC9  = 8'h39;  // '9'
    localparam logic [7:0] CH_ALO   = 8'h61;  // 'a'
    localparam logic [7:0] CH_AHI   = 8'h76;  // 'v'
    localparam logic [7:0] ALPHA_BASE = 8'd10;

    // Result kinds.
    localparam logic KIND_RECORD = 1'b0;
    localparam logic KIND_SEQ    = 1'b1;

    typedef enum logic [1:0] {
        OP_DIGIT  = 2'd0,
        OP_RECORD = 2'd1,
        OP_SEQ    = 2'd2
    } t_op;

    typedef struct packed {
        t_op                op;
        logic [POS_W-1:0]   idx;
        logic [DIGIT_W-1:0] value;
        logic               err;
    } t_cmd;

endpackage

### rtl/core/bsfd_cmd_fifo.sv
// Short command queue that decouples the parser front from the result back.
// Depends on bsfd_pkg for the command type and the queue depth.
module bsfd_cmd_fifo
    import bsfd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_push_data,
    input  logic i_pop,
    output t_cmd o_head,
    output logic o_full,
    output logic o_empty
);

    t_cmd                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr;
    logic [QUEUE_CW-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == QUEUE_CW'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

### rtl/core/bsfd_front.sv
// Parser front: tracks the framing mode, decodes digit characters and
// issues digit, record and sequence commands. Depends on bsfd_pkg.
module bsfd_front
    import bsfd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_byte,
    output logic       o_push,
    output t_cmd       o_cmd
);

    typedef enum logic [1:0] {
        M_IDLE  = 2'd0,
        M_FRAME = 2'd1,
        M_SKIP  = 2'd2
    } t_mode;

    t_mode            r_mode, n_mode;
    logic [POS_W-1:0] r_pos, n_pos;
    logic             r_err, n_err;

    logic [DIGIT_W-1:0] dig_val;
    logic               dig_bad;
    logic [7:0]         dec_off;
    logic [7:0]         alpha_off;

    // Character to digit value; invalid characters decode to zero.
    always_comb begin
        dec_off   = i_byte - CH_DEC0;
        alpha_off = i_byte - CH_ALO + ALPHA_BASE;
        dig_bad   = 1'b0;
        dig_val   = '0;
        if (i_byte >= CH_DEC0 && i_byte <= CH_DEC9) begin
            dig_val = dec_off[DIGIT_W-1:0];
        end else if (i_byte >= CH_ALO && i_byte <= CH_AHI) begin
            dig_val = alpha_off[DIGIT_W-1:0];
        end else begin
            dig_bad = 1'b1;
        end
    end

    always_comb begin
        n_mode      = r_mode;
        n_pos       = r_pos;
        n_err       = r_err;
        o_push      = 1'b0;
        o_cmd.op    = OP_DIGIT;
        o_cmd.idx   = r_pos;
        o_cmd.value = dig_val;
        o_cmd.err   = r_err;
        if (i_accept) begin
            case (r_mode)
                M_FRAME: begin
                    if (r_pos < POS_W'(FRAME_DIGITS)) begin
                        o_push = 1'b1;
                        n_pos  = r_pos + 1'b1;
                        n_err  = r_err | dig_bad;
                    end else begin
                        n_mode = M_IDLE;
                        n_pos  = '0;
                        if (i_byte == CH_END) begin
                            o_push   = 1'b1;
                            o_cmd.op = OP_RECORD;
                        end
                    end
                end
                M_SKIP: begin
                    if (i_byte == CH_SEQ) begin
                        n_mode   = M_IDLE;
                        o_push   = 1'b1;
                        o_cmd.op = OP_SEQ;
                    end
                end
                default: begin
                    n_mode = M_IDLE;
                    if (i_byte == CH_START) begin
                        n_mode = M_FRAME;
                        n_pos  = '0;
                        n_err  = 1'b0;
                    end else if (i_byte == CH_SEQ) begin
                        o_push   = 1'b1;
                        o_cmd.op = OP_SEQ;
                    end else if (i_byte == CH_SKIP) begin
                        n_mode = M_SKIP;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE;
            r_pos  <= '0;
            r_err  <= 1'b0;
        end else begin
            r_mode <= n_mode;
            r_pos  <= n_pos;
            r_err  <= n_err;
        end
    end

endmodule

### rtl/core/bsfd_back.sv
// Result back: holds the digit store and the sequence counter, executes
// queued commands and drives the output register. Depends on bsfd_pkg.
module bsfd_back
    import bsfd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_empty,
    input  t_cmd               i_head,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_result_kind,
    output logic [TS_W-1:0]    o_time_stamp,
    output logic [FORCE_W-1:0] o_force_value,
    output logic [STIM_W-1:0]  o_stimulus,
    output logic [FREQ_W-1:0]  o_frequency,
    output logic [SEQ_W-1:0]   o_sequence_number,
    output logic               o_bad_digit
);

    logic [DIGIT_W-1:0] r_store [STORE_DEPTH];
    logic [SEQ_W-1:0]   r_seq;
    logic               r_out_valid;
    logic               r_kind;
    logic [TS_W-1:0]    r_ts;
    logic [FORCE_W-1:0] r_force;
    logic [STIM_W-1:0]  r_stim;
    logic [FREQ_W-1:0]  r_freq;
    logic [SEQ_W-1:0]   r_seq_out;
    logic               r_bad;

    logic [DIGIT_W-1:0] dig [STORE_DEPTH];
    logic               slot_free;
    logic               load;
    logic [SEQ_W-1:0]   seq_inc;

    // Digits beyond the frame length read as zero.
    always_comb begin
        for (int k = 0; k < STORE_DEPTH; k++) begin
            dig[k] = (k < FRAME_DIGITS) ? r_store[k] : '0;
        end
    end

    assign slot_free = !r_out_valid || i_out_ready;
    assign o_pop     = !i_empty && (i_head.op == OP_DIGIT || slot_free);
    assign load      = o_pop && (i_head.op != OP_DIGIT);
    assign seq_inc   = r_seq + 1'b1;

    always_ff @(posedge i_clk) begin
        if (o_pop && i_head.op == OP_DIGIT) begin
            for (int k = 0; k < STORE_DEPTH; k++) begin
                if (i_head.idx == POS_W'(k)) begin
                    r_store[k] <= i_head.value;
                end
            end
        end
        if (load) begin
            if (i_head.op == OP_RECORD) begin
                r_kind    <= KIND_RECORD;
                r_ts      <= {dig[6], dig[5], dig[4], dig[3], dig[2], dig[1], dig[0]};
                r_force   <= {dig[9], dig[8], dig[7]};
                r_stim    <= dig[10];
                r_freq    <= {dig[13], dig[12], dig[11]};
                r_seq_out <= r_seq;
                r_bad     <= i_head.err;
            end else begin
                r_kind    <= KIND_SEQ;
                r_ts      <= '0;
                r_force   <= '0;
                r_stim    <= '0;
                r_freq    <= '0;
                r_seq_out <= seq_inc;
                r_bad     <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (load && i_head.op == OP_SEQ) begin
                r_seq <= seq_inc;
            end
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_result_kind     = r_kind;
    assign o_time_stamp      = r_ts;
    assign o_force_value     = r_force;
    assign o_stimulus        = r_stim;
    assign o_frequency       = r_freq;
    assign o_sequence_number = r_seq_out;
    assign o_bad_digit       = r_bad;

endmodule

### rtl/core/base32_sensor_frame_deframer_top.sv
// Top level of the base-32 sensor frame deframer.
// Depends on bsfd_pkg, bsfd_front, bsfd_cmd_fifo and bsfd_back.
//
// The block takes one received character per word and turns framed sensor
// traffic into result words. An 'S' seen while idle opens a frame of
// fourteen base-32 digits ('0'-'9', 'a'-'v'), which must be followed by an
// 'E'; the frame then yields a data record with a 35-bit timestamp, a
// 15-bit force value, a 5-bit stimulus code and a 15-bit frequency, each
// assembled least significant digit first. Characters that are not valid
// digits count as zero and raise bad_digit on the record. A frame that is
// not closed by 'E' is dropped silently. An idle 'Y' bumps the 16-bit
// sequence number and reports it as a sequence word; an idle 'N' discards
// everything up to the next 'Y'. The input side takes one character per
// clock cycle while the queue has room, and the block produces at most one
// result word for each character. A parser front classifies each character
// in the cycle it is accepted and places a command in a four-entry queue;
// a back end drains the queue at one command per cycle, holding a result
// command while the output register is still full, writing digits into
// the digit store and loading finished results into the output register.
// Because of that register and the queue, input stays ready while a result
// waits to be taken, and only stops when four commands are pending behind
// a stalled output. A character's command is first registered in the
// queue, and its result word is then loaded into the output register.
module base32_sensor_frame_deframer_top
    import bsfd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [7:0]         i_rx_byte,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_result_kind,
    output logic [TS_W-1:0]    o_time_stamp,
    output logic [FORCE_W-1:0] o_force_value,
    output logic [STIM_W-1:0]  o_stimulus,
    output logic [FREQ_W-1:0]  o_frequency,
    output logic [SEQ_W-1:0]   o_sequence_number,
    output logic               o_bad_digit
);

    logic in_accept;
    logic push;
    t_cmd push_cmd;
    t_cmd head;
    logic pop;
    logic full;
    logic empty;

    // The front may always issue a command when the queue has room.
    assign o_in_ready = !full;
    assign in_accept  = i_in_valid && o_in_ready;

    bsfd_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_byte   (i_rx_byte),
        .o_push   (push),
        .o_cmd    (push_cmd)
    );

    bsfd_cmd_fifo u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_cmd),
        .i_pop       (pop),
        .o_head      (head),
        .o_full      (full),
        .o_empty     (empty)
    );

    bsfd_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_empty           (empty),
        .i_head            (head),
        .o_pop             (pop),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_result_kind     (o_result_kind),
        .o_time_stamp      (o_time_stamp),
        .o_force_value     (o_force_value),
        .o_stimulus        (o_stimulus),
        .o_frequency       (o_frequency),
        .o_sequence_number (o_sequence_number),
        .o_bad_digit       (o_bad_digit)
    );

endmodule
